// ----- rtl/tiu_pkg.sv -----
`timescale 1ns / 1ps

package tiu_pkg;

    localparam int XLEN       = 64;
    localparam int CFG_ADDR_W = 6;

    // operation codes
    localparam logic [2:0] FUNC_EXC    = 3'd0;
    localparam logic [2:0] FUNC_MRET   = 3'd1;
    localparam logic [2:0] FUNC_SRET   = 3'd2;
    localparam logic [2:0] FUNC_SAMPLE = 3'd3;
    localparam logic [2:0] FUNC_STATUS = 3'd4;

    // configuration register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_MTVEC   = 3'd0;
    localparam logic [2:0] REG_STVEC   = 3'd1;
    localparam logic [2:0] REG_MEDELEG = 3'd2;
    localparam logic [2:0] REG_MIDELEG = 3'd3;
    localparam logic [2:0] REG_MIE     = 3'd4;

    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // timer routing
    localparam logic [1:0] ROUTE_NONE = 2'd0;
    localparam logic [1:0] ROUTE_STI  = 2'd1;
    localparam logic [1:0] ROUTE_MTI  = 2'd2;

    // vector mode field
    localparam logic [1:0] VEC_MODE_VECTORED = 2'd1;

    // mstatus bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;
    localparam int ST_MPRV = 17;

    // interrupt codes, also their bit positions in mip / mie
    localparam logic [5:0] IRQ_STI = 6'd5;
    localparam logic [5:0] IRQ_MTI = 6'd7;
    localparam logic [5:0] IRQ_SEI = 6'd9;
    localparam logic [5:0] IRQ_MEI = 6'd11;

    typedef struct packed {
        logic [2:0]      func;
        logic [5:0]      cause_code;
        logic [XLEN-1:0] data;
        logic [XLEN-1:0] current_pc;
        logic            timer_line;
        logic            machine_ext_line;
        logic            super_ext_line;
    } tiu_item_t;

    typedef struct packed {
        logic            redirect;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      priv_mode;
        logic            trap_taken;
        logic            to_supervisor;
        logic [XLEN-1:0] trap_cause;
        logic [XLEN-1:0] status_image;
        logic [XLEN-1:0] pending_image;
    } tiu_result_t;

    typedef struct packed {
        logic [XLEN-1:0] mtvec;
        logic [XLEN-1:0] stvec;
        logic [XLEN-1:0] medeleg;
        logic [XLEN-1:0] mideleg;
        logic [XLEN-1:0] mie;
    } tiu_cfg_t;

    typedef struct packed {
        logic [1:0]      priv;
        logic [XLEN-1:0] mstatus;
        logic [XLEN-1:0] mip;
        logic [1:0]      troute;
        logic [XLEN-1:0] mepc;
        logic [XLEN-1:0] sepc;
        logic [XLEN-1:0] mcause;
        logic [XLEN-1:0] scause;
        logic [XLEN-1:0] mtval;
        logic [XLEN-1:0] stval;
    } tiu_state_t;

endpackage

// ----- rtl/tiu_in_if.sv -----
`timescale 1ns / 1ps

interface tiu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [5:0]  cause_code;
    logic [63:0] data;
    logic [63:0] current_pc;
    logic        timer_line;
    logic        machine_ext_line;
    logic        super_ext_line;

    modport source
    (
        output valid, func, cause_code, data, current_pc,
               timer_line, machine_ext_line, super_ext_line,
        input  ready
    );

    modport sink
    (
        input  valid, func, cause_code, data, current_pc,
               timer_line, machine_ext_line, super_ext_line,
        output ready
    );
endinterface

// ----- rtl/tiu_out_if.sv -----
`timescale 1ns / 1ps

interface tiu_out_if;
    logic        valid;
    logic        ready;
    logic        redirect;
    logic [63:0] next_pc;
    logic [1:0]  priv_mode;
    logic        trap_taken;
    logic        to_supervisor;
    logic [63:0] trap_cause;
    logic [63:0] status_image;
    logic [63:0] pending_image;

    modport source
    (
        output valid, redirect, next_pc, priv_mode, trap_taken, to_supervisor,
               trap_cause, status_image, pending_image,
        input  ready
    );

    modport sink
    (
        input  valid, redirect, next_pc, priv_mode, trap_taken, to_supervisor,
               trap_cause, status_image, pending_image,
        output ready
    );
endinterface

// ----- rtl/tiu_csr_regs.sv -----
`timescale 1ns / 1ps

module tiu_csr_regs
    import tiu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [XLEN-1:0]       pwdata,
    output logic [XLEN-1:0]       prdata,
    output logic                  pready,
    output tiu_cfg_t              cfg
);

    tiu_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[5:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MTVEC:   cfg_reg.mtvec   <= pwdata;
                REG_STVEC:   cfg_reg.stvec   <= pwdata;
                REG_MEDELEG: cfg_reg.medeleg <= pwdata;
                REG_MIDELEG: cfg_reg.mideleg <= pwdata;
                REG_MIE:     cfg_reg.mie     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MTVEC:   prdata = cfg_reg.mtvec;
            REG_STVEC:   prdata = cfg_reg.stvec;
            REG_MEDELEG: prdata = cfg_reg.medeleg;
            REG_MIDELEG: prdata = cfg_reg.mideleg;
            REG_MIE:     prdata = cfg_reg.mie;
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- rtl/tiu_trap_logic.sv -----
`timescale 1ns / 1ps

module tiu_trap_logic
    import tiu_pkg::*;
(
    input  tiu_state_t  st,
    input  tiu_cfg_t    cfg,
    input  tiu_item_t   item,
    output tiu_state_t  st_next,
    output tiu_result_t res
);

    logic [XLEN-1:0] mip_s;
    logic [1:0]      route_s;
    logic            m_en;
    logic            s_en;
    logic            irq_hit;
    logic [5:0]      irq_code;
    logic            is_trap;
    logic            is_int;
    logic [5:0]      code;
    logic [XLEN-1:0] cause;
    logic [XLEN-1:0] tval;
    logic [XLEN-1:0] deleg_vec;
    logic            deleg;
    logic [XLEN-1:0] base;
    logic [XLEN-1:0] npc;
    logic [XLEN-1:0] s;
    logic [1:0]      mpp;
    logic [1:0]      nm;

    // platform sample: update pending bits, timer bit follows delegation
    always_comb
    begin
        mip_s   = st.mip;
        route_s = st.troute;
        if (item.timer_line)
        begin
            if (cfg.mideleg[IRQ_STI])
            begin
                mip_s[IRQ_STI] = 1'b1;
                mip_s[IRQ_MTI] = 1'b0;
                route_s        = ROUTE_STI;
            end
            else
            begin
                mip_s[IRQ_MTI] = 1'b1;
                mip_s[IRQ_STI] = 1'b0;
                route_s        = ROUTE_MTI;
            end
        end
        else if (st.troute != ROUTE_NONE)
        begin
            if (st.troute == ROUTE_STI)
                mip_s[IRQ_STI] = 1'b0;
            else
                mip_s[IRQ_MTI] = 1'b0;
            route_s = ROUTE_NONE;
        end
        mip_s[IRQ_MEI] = item.machine_ext_line;
        mip_s[IRQ_SEI] = item.super_ext_line;
    end

    // interrupt selection, fixed priority MEI, MTI, SEI, STI
    always_comb
    begin
        m_en     = (st.priv == PRIV_M) ? st.mstatus[ST_MIE] : 1'b1;
        s_en     = (st.priv == PRIV_S) ? st.mstatus[ST_SIE] : (st.priv == PRIV_U);
        irq_hit  = 1'b1;
        irq_code = IRQ_MEI;
        if (cfg.mie[IRQ_MEI] && mip_s[IRQ_MEI] && m_en)
            irq_code = IRQ_MEI;
        else if (cfg.mie[IRQ_MTI] && mip_s[IRQ_MTI] && m_en)
            irq_code = IRQ_MTI;
        else if (cfg.mideleg[IRQ_SEI] && cfg.mie[IRQ_SEI] && mip_s[IRQ_SEI] && s_en)
            irq_code = IRQ_SEI;
        else if (cfg.mideleg[IRQ_STI] && cfg.mie[IRQ_STI] && mip_s[IRQ_STI] && s_en)
            irq_code = IRQ_STI;
        else
            irq_hit = 1'b0;
    end

    // trap entry: delegation and vector target
    always_comb
    begin
        is_int    = (item.func == FUNC_SAMPLE);
        is_trap   = (item.func == FUNC_EXC) || (is_int && irq_hit);
        code      = is_int ? irq_code : item.cause_code;
        cause     = {is_int, {(XLEN-7){1'b0}}, code};
        tval      = is_int ? '0 : item.data;
        deleg_vec = is_int ? cfg.mideleg : cfg.medeleg;
        deleg     = (st.priv != PRIV_M) && deleg_vec[code];
        base      = deleg ? cfg.stvec : cfg.mtvec;
        npc       = {base[XLEN-1:2], 2'b00};
        if (is_int && base[1:0] == VEC_MODE_VECTORED)
            npc = npc + {{(XLEN-8){1'b0}}, code, 2'b00};
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        s       = st.mstatus;
        mpp     = s[ST_MPP +: 2];
        nm      = PRIV_M;

        case (item.func)
            FUNC_MRET:
            begin
                if (mpp == PRIV_U)
                    nm = PRIV_U;
                else if (mpp == PRIV_S)
                    nm = PRIV_S;
                else
                    nm = PRIV_M;
                s[ST_MIE]      = s[ST_MPIE];
                s[ST_MPIE]     = 1'b1;
                s[ST_MPP +: 2] = 2'b00;
                if (nm != PRIV_M)
                    s[ST_MPRV] = 1'b0;
                st_next.mstatus = s;
                st_next.priv    = nm;
                res.redirect    = 1'b1;
                res.next_pc     = st.mepc;
            end
            FUNC_SRET:
            begin
                nm              = s[ST_SPP] ? PRIV_S : PRIV_U;
                s[ST_SIE]       = s[ST_SPIE];
                s[ST_SPIE]      = 1'b1;
                s[ST_SPP]       = 1'b0;
                s[ST_MPRV]      = 1'b0;
                st_next.mstatus = s;
                st_next.priv    = nm;
                res.redirect    = 1'b1;
                res.next_pc     = st.sepc;
            end
            FUNC_STATUS:
            begin
                st_next.mstatus = item.data;
            end
            default: ;
        endcase

        if (is_int)
        begin
            st_next.mip    = mip_s;
            st_next.troute = route_s;
            if (irq_hit)
                st_next.mip[irq_code] = 1'b0;
        end

        if (is_trap)
        begin
            if (deleg)
            begin
                s[ST_SPIE] = s[ST_SIE];
                s[ST_SIE]  = 1'b0;
                s[ST_SPP]  = (st.priv == PRIV_S);
                st_next.sepc   = item.current_pc;
                st_next.scause = cause;
                st_next.stval  = tval;
                st_next.priv   = PRIV_S;
            end
            else
            begin
                s[ST_MPIE]     = s[ST_MIE];
                s[ST_MIE]      = 1'b0;
                s[ST_MPP +: 2] = st.priv;
                st_next.mepc   = item.current_pc;
                st_next.mcause = cause;
                st_next.mtval  = tval;
                st_next.priv   = PRIV_M;
            end
            st_next.mstatus   = s;
            res.redirect      = 1'b1;
            res.next_pc       = npc;
            res.trap_taken    = 1'b1;
            res.to_supervisor = deleg;
            res.trap_cause    = cause;
        end

        res.priv_mode     = st_next.priv;
        res.status_image  = st_next.mstatus;
        res.pending_image = st_next.mip;
    end

endmodule

// ----- rtl/trap_and_interrupt_unit.sv -----
`timescale 1ns / 1ps
// Channel   Role       Handshake      Payload
// in_ch     sink       valid/ready    func, cause_code, data, current_pc, three lines
// out_ch    source     valid/ready    redirect, next_pc, priv_mode, trap fields, images
// apb       slave      psel/penable   five 64-bit registers at 8 * index, pready tied high
//
// One item per cycle sustained while out_ch does not stall; an accepted item passes
// the input register, then trap logic into the result register, before its result leaves.
// rst_n clears control, privilege (to machine) and all trap state at once.
// A stalled out_ch holds the result register; the input register still takes
// one more item and in_ch.ready drops only when both are full.

module trap_and_interrupt_unit
    import tiu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tiu_in_if.sink                in_ch,
    tiu_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [XLEN-1:0]       pwdata,
    output logic [XLEN-1:0]       prdata,
    output logic                  pready
);

    tiu_cfg_t    cfg;
    tiu_state_t  st_reg;
    tiu_state_t  st_next;
    tiu_item_t   item_reg;
    tiu_item_t   item_in;
    tiu_result_t res_reg;
    tiu_result_t res_next;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        take_in;

    tiu_csr_regs u_csr
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tiu_trap_logic u_logic
    (
        .st      (st_reg),
        .cfg     (cfg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign item_in.func             = in_ch.func;
    assign item_in.cause_code       = in_ch.cause_code;
    assign item_in.data             = in_ch.data;
    assign item_in.current_pc       = in_ch.current_pc;
    assign item_in.timer_line       = in_ch.timer_line;
    assign item_in.machine_ext_line = in_ch.machine_ext_line;
    assign item_in.super_ext_line   = in_ch.super_ext_line;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign take_in     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            // priv is the top field of the state; everything else clears
            st_reg        <= {PRIV_M, {($bits(tiu_state_t)-2){1'b0}}};
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.redirect      = res_reg.redirect;
    assign out_ch.next_pc       = res_reg.next_pc;
    assign out_ch.priv_mode     = res_reg.priv_mode;
    assign out_ch.trap_taken    = res_reg.trap_taken;
    assign out_ch.to_supervisor = res_reg.to_supervisor;
    assign out_ch.trap_cause    = res_reg.trap_cause;
    assign out_ch.status_image  = res_reg.status_image;
    assign out_ch.pending_image = res_reg.pending_image;

endmodule
